// ===== src/usn_pkg.sv =====
// Shared types and constants of the UTF-8 script normalizer.
// No dependencies; imported by the front end, the back end and the top level.
`default_nettype none

package usn_pkg;

    // script_mode codes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_HANGUL = 2'd1;
    localparam logic [1:0] MODE_KANA   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [20:0] HANGUL_FIRST = 21'h00AC00;
    localparam logic [20:0] HANGUL_LAST  = 21'h00D7A3;
    localparam logic [20:0] KATA_FIRST   = 21'h0030A1;
    localparam logic [20:0] KATA_LAST    = 21'h0030F6;
    localparam logic [20:0] KANA_SHIFT   = 21'h000060;

    localparam logic [15:0] JAMO_L_BASE  = 16'h1100;
    localparam logic [15:0] JAMO_V_BASE  = 16'h1161;
    // final Jamo base minus one: final index zero means no final
    localparam logic [15:0] JAMO_T_PRE   = 16'h11A7;

    localparam logic [4:0]  JAMO_V_COUNT = 5'd21;
    localparam logic [4:0]  JAMO_T_COUNT = 5'd28;

    // floor(s / 28) = (s * 18725) >> 19 for s < 11172
    localparam logic [14:0] Q28_RECIP = 15'd18725;
    localparam int          Q28_SHIFT = 19;
    // floor(q / 21) = (q * 391) >> 13 for q < 399
    localparam logic [8:0]  INI_RECIP = 9'd391;
    localparam int          INI_SHIFT = 13;

    // one decoded item queued for the emitter: up to three code points
    typedef struct packed {
        logic        raw;     // copy cp0[7:0] as a single byte
        logic [1:0]  ncp_m1;  // number of code points minus one
        logic [20:0] cp0;
        logic [15:0] cp1;
        logic [15:0] cp2;
    } usn_entry_t;

endpackage

`default_nettype wire

// ===== src/usn_front.sv =====
// Front end: accepts bytes, runs the lenient UTF-8 decoder and maps the code point.
// Splits Hangul syllables in a three-stage reciprocal pipeline; uses usn_pkg.
`default_nettype none

module usn_front
    import usn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  script_mode,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        queue_full,
    output logic             push_valid,
    output usn_entry_t       push_entry
);

    logic [20:0] part_reg, part_next;
    logic [1:0]  exp_reg, exp_next;

    logic        a_valid_reg, a_raw_reg, a_hangul_reg;
    logic [20:0] a_cp_reg;
    logic [13:0] a_s_reg;

    logic        b_valid_reg, b_raw_reg, b_hangul_reg;
    logic [20:0] b_cp_reg;
    logic [13:0] b_s_reg;
    logic [8:0]  b_q28_reg;

    logic        c_valid_reg, c_raw_reg, c_hangul_reg;
    logic [20:0] c_cp_reg;
    logic [8:0]  c_q28_reg;
    logic [4:0]  c_ini_reg, c_fin_reg;

    logic        adv, accept, mode_pass, lead_ok, complete, emit;
    logic        is_hangul, is_kana;
    logic [20:0] dec_cp, map_cp, hofs;
    logic [1:0]  dec_need;
    logic [28:0] q28_prod;
    logic [13:0] q28_x28, fin_full;
    logic [17:0] ini_prod;
    logic [8:0]  ini_x21, med_full;
    logic [4:0]  med;

    assign adv      = !c_valid_reg || !queue_full;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    assign mode_pass = (script_mode == MODE_PASS) || (script_mode == MODE_UNUSED);

    always_comb begin
        dec_cp   = '0;
        dec_need = 2'd0;
        lead_ok  = 1'b1;
        if (exp_reg == 2'd0) begin
            priority if (!s_tdata[7]) begin
                dec_cp = {14'd0, s_tdata[6:0]};
            end else if (s_tdata[7:5] == 3'b110) begin
                dec_cp   = {16'd0, s_tdata[4:0]};
                dec_need = 2'd1;
            end else if (s_tdata[7:4] == 4'b1110) begin
                dec_cp   = {17'd0, s_tdata[3:0]};
                dec_need = 2'd2;
            end else if (s_tdata[7:3] == 5'b11110) begin
                dec_cp   = {18'd0, s_tdata[2:0]};
                dec_need = 2'd3;
            end else begin
                lead_ok = 1'b0;
            end
        end else begin
            // continuation taken unchecked: low six bits only
            dec_cp   = {part_reg[14:0], s_tdata[5:0]};
            dec_need = exp_reg - 2'd1;
        end
    end

    assign complete = lead_ok && ((dec_need == 2'd0) || s_tlast);
    assign emit     = mode_pass || complete;

    always_comb begin
        part_next = part_reg;
        exp_next  = exp_reg;
        if (accept) begin
            if (mode_pass || complete) begin
                part_next = '0;
                exp_next  = 2'd0;
            end else if (lead_ok) begin
                part_next = dec_cp;
                exp_next  = dec_need;
            end
        end
    end

    assign is_hangul = (script_mode == MODE_HANGUL) && (dec_cp >= HANGUL_FIRST)
                       && (dec_cp <= HANGUL_LAST);
    assign is_kana   = (script_mode == MODE_KANA) && (dec_cp >= KATA_FIRST)
                       && (dec_cp <= KATA_LAST);
    assign map_cp    = is_kana ? (dec_cp - KANA_SHIFT) : dec_cp;
    assign hofs      = dec_cp - HANGUL_FIRST;

    // stage B: syllable offset / 28
    assign q28_prod = 29'(a_s_reg) * 29'(Q28_RECIP);
    // stage C: final index and initial index
    assign q28_x28  = 14'(b_q28_reg) * 14'(JAMO_T_COUNT);
    assign fin_full = b_s_reg - q28_x28;
    assign ini_prod = 18'(b_q28_reg) * 18'(INI_RECIP);
    // queue entry: medial index
    assign ini_x21  = 9'(c_ini_reg) * 9'(JAMO_V_COUNT);
    assign med_full = c_q28_reg - ini_x21;
    assign med      = med_full[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg    <= '0;
            exp_reg     <= 2'd0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            part_reg <= part_next;
            exp_reg  <= exp_next;
            if (adv) begin
                a_valid_reg <= accept && emit;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_raw_reg    <= mode_pass;
            a_hangul_reg <= !mode_pass && is_hangul;
            a_cp_reg     <= mode_pass ? {13'd0, s_tdata} : map_cp;
            a_s_reg      <= hofs[13:0];

            b_raw_reg    <= a_raw_reg;
            b_hangul_reg <= a_hangul_reg;
            b_cp_reg     <= a_cp_reg;
            b_s_reg      <= a_s_reg;
            b_q28_reg    <= q28_prod[27:Q28_SHIFT];

            c_raw_reg    <= b_raw_reg;
            c_hangul_reg <= b_hangul_reg;
            c_cp_reg     <= b_cp_reg;
            c_q28_reg    <= b_q28_reg;
            c_ini_reg    <= ini_prod[17:INI_SHIFT];
            c_fin_reg    <= fin_full[4:0];
        end
    end

    assign push_valid = c_valid_reg && !queue_full;

    always_comb begin
        push_entry = '0;
        if (c_hangul_reg) begin
            push_entry.cp0    = {5'd0, JAMO_L_BASE + 16'(c_ini_reg)};
            push_entry.cp1    = JAMO_V_BASE + 16'(med);
            push_entry.cp2    = JAMO_T_PRE + 16'(c_fin_reg);
            push_entry.ncp_m1 = (c_fin_reg != 5'd0) ? 2'd2 : 2'd1;
        end else begin
            push_entry.raw = c_raw_reg;
            push_entry.cp0 = c_cp_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/usn_fifo.sv =====
// Short register queue between the front end and the emitter.
// Generic width and depth; no package dependencies.
`default_nettype none

module usn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/usn_back.sv =====
// Emitter: takes queued code points and sends their shortest UTF-8 bytes, or a raw
// entry's byte, one a cycle while m_tready is high. Uses usn_pkg for queue entries.
`default_nettype none

module usn_back
    import usn_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       head_valid,
    input  usn_entry_t      head_data,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic       busy_reg;
    usn_entry_t cur_reg;
    logic [1:0] cp_sel_reg, byte_sel_reg;

    logic [20:0] cur_cp;
    logic [1:0]  lm1, rem;
    logic        cp_done, item_done, fire;

    always_comb begin
        unique case (cp_sel_reg)
            2'd0:    cur_cp = cur_reg.cp0;
            2'd1:    cur_cp = {5'd0, cur_reg.cp1};
            default: cur_cp = {5'd0, cur_reg.cp2};
        endcase
    end

    // encoded length minus one
    always_comb begin
        priority if (cur_reg.raw || cur_cp < 21'h80) begin
            lm1 = 2'd0;
        end else if (cur_cp < 21'h800) begin
            lm1 = 2'd1;
        end else if (cur_cp < 21'h10000) begin
            lm1 = 2'd2;
        end else begin
            lm1 = 2'd3;
        end
    end

    assign rem = lm1 - byte_sel_reg;

    always_comb begin
        if (byte_sel_reg == 2'd0) begin
            if (cur_reg.raw) begin
                m_tdata = cur_cp[7:0];
            end else begin
                unique case (lm1)
                    2'd0:    m_tdata = {1'b0, cur_cp[6:0]};
                    2'd1:    m_tdata = {3'b110, cur_cp[10:6]};
                    2'd2:    m_tdata = {4'b1110, cur_cp[15:12]};
                    default: m_tdata = {5'b11110, cur_cp[20:18]};
                endcase
            end
        end else begin
            unique case (rem)
                2'd0:    m_tdata = {2'b10, cur_cp[5:0]};
                2'd1:    m_tdata = {2'b10, cur_cp[11:6]};
                default: m_tdata = {2'b10, cur_cp[17:12]};
            endcase
        end
    end

    assign cp_done   = (byte_sel_reg == lm1);
    assign item_done = cp_done && (cp_sel_reg == cur_reg.ncp_m1);
    assign m_tvalid  = busy_reg;
    assign m_tlast   = item_done;
    assign fire      = busy_reg && m_tready;
    // reload in the cycle the last byte leaves: no bubble between items
    assign pop       = head_valid && (!busy_reg || (fire && item_done));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cp_sel_reg   <= 2'd0;
            byte_sel_reg <= 2'd0;
        end else if (pop) begin
            busy_reg     <= 1'b1;
            cp_sel_reg   <= 2'd0;
            byte_sel_reg <= 2'd0;
        end else if (fire) begin
            if (item_done) begin
                busy_reg <= 1'b0;
            end else if (cp_done) begin
                cp_sel_reg   <= cp_sel_reg + 2'd1;
                byte_sel_reg <= 2'd0;
            end else begin
                byte_sel_reg <= byte_sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/utf8_script_normalizer_top.sv =====
// Top level of the UTF-8 script normalizer: mode register, front end, queue, emitter.
// Depends on usn_pkg, usn_front, usn_fifo and usn_back.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] in_byte, s_tlast end_of_text
//  m_      | out | m_tvalid/m_tready  | m_tdata[7:0] out_byte, m_tlast run_last
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data[1:0] script_mode
//
// The front end takes one byte per cycle while s_tready is high; the emitter sends
// one byte per cycle while m_tready is high. An input byte causes 0 to 9 output
// bytes, two or three per byte on Hangul text. The item completed by an accepted byte
// passes stages A, B, C and the queue before m_tvalid rises. Reset clears decoder,
// pipeline and queue. A stalled m_ side fills the queue, then s_tready drops.
`default_nettype none

module utf8_script_normalizer_top
    import usn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,    // script_mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,        // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,        // [7:0] out_byte
    output logic            m_tlast
);

    logic [1:0] mode_reg;
    logic       q_full, q_push, q_pop, q_head_valid;
    usn_entry_t q_push_entry, q_head_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PASS;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    usn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .script_mode (mode_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .queue_full  (q_full),
        .push_valid  (q_push),
        .push_entry  (q_push_entry)
    );

    usn_fifo #(
        .WIDTH ($bits(usn_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_entry)
    );

    usn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_data  (q_head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== src/usn_checker.sv =====
// Port-level assertions for the UTF-8 script normalizer, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module usn_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    logic seen_reg;

    // track whether any item has entered since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            seen_reg <= 1'b1;
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> seen_reg)
        else $error("output item with no input item taken");

endmodule

bind utf8_script_normalizer_top usn_checker u_usn_checker (.*);

`default_nettype wire

// ===== bench/usn_stream_checker.sv =====
// Stream checker for the UTF-8 script normalizer: watches the config, s_ and m_ channels.
// Holds its own transcoder model and the queue of expected output bytes; needs usn_pkg.
// Reports the mismatch count and the number of output bytes still awaited.
module usn_stream_checker
    import usn_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,   // script_mode
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] in_byte
    input  wire logic       s_tlast,       // end_of_text
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,       // [7:0] out_byte
    input  wire logic       m_tlast,       // run_last
    output int              fail_count,
    output int              pending_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    out_byte_t   expected_bytes [$];
    logic [1:0]  cur_mode;
    logic [20:0] acc_cp;
    logic [1:0]  acc_need;

    // add one expected item at the tail
    task automatic append_item(input out_byte_t e);
        expected_bytes.insert(expected_bytes.size(), e);
    endtask

    task automatic push_byte(input logic [7:0] b);
        append_item('{data: b, last: 1'b0});
    endtask

    // shortest UTF-8 form of one code point
    task automatic push_codepoint(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end else begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic emit_mapped(input logic [20:0] cp);
        int        syl;
        int        ini;
        int        med;
        int        fin;
        out_byte_t tail;
        if (cur_mode == MODE_HANGUL && cp >= HANGUL_FIRST && cp <= HANGUL_LAST) begin
            syl = int'(cp - HANGUL_FIRST);
            ini = syl / (int'(JAMO_V_COUNT) * int'(JAMO_T_COUNT));
            med = (syl % (int'(JAMO_V_COUNT) * int'(JAMO_T_COUNT))) / int'(JAMO_T_COUNT);
            fin = syl % int'(JAMO_T_COUNT);
            push_codepoint(21'(int'(JAMO_L_BASE) + ini));
            push_codepoint(21'(int'(JAMO_V_BASE) + med));
            if (fin > 0)
                push_codepoint(21'(int'(JAMO_T_PRE) + fin));
        end else if (cur_mode == MODE_KANA && cp >= KATA_FIRST && cp <= KATA_LAST) begin
            push_codepoint(cp - KANA_SHIFT);
        end else begin
            push_codepoint(cp);
        end
        // mark the final byte of this run
        tail = expected_bytes.pop_back();
        tail.last = 1'b1;
        append_item(tail);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eot);
        logic [20:0] cp;
        logic [1:0]  need;
        logic        skip;
        cp = '0;
        need = '0;
        skip = 1'b0;
        if (cur_mode == MODE_PASS || cur_mode == MODE_UNUSED) begin
            acc_cp = '0;
            acc_need = '0;
            append_item('{data: b, last: 1'b1});
        end else begin
            if (acc_need == 2'd0) begin
                if (!b[7]) begin
                    cp = {13'd0, b};
                end else if (b[7:5] == 3'b110) begin
                    cp = {16'd0, b[4:0]};
                    need = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    cp = {17'd0, b[3:0]};
                    need = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    cp = {18'd0, b[2:0]};
                    need = 2'd3;
                end else begin
                    skip = 1'b1;
                end
            end else begin
                // any byte counts as a continuation here
                cp = {acc_cp[14:0], b[5:0]};
                need = acc_need - 2'd1;
            end
            if (!skip) begin
                if (need != 2'd0 && !eot) begin
                    acc_cp = cp;
                    acc_need = need;
                end else begin
                    acc_cp = '0;
                    acc_need = '0;
                    emit_mapped(cp);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        out_byte_t want;
        if (!aresetn) begin
            cur_mode = MODE_PASS;
            acc_cp = '0;
            acc_need = '0;
            expected_bytes.delete();
            fail_count = 0;
        end else begin
            // an item taken at this edge still sees the old mode
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (cfg_wr_en)
                cur_mode = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected item: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_bytes.size();
    end

endmodule

// ===== bench/utf8_script_normalizer_top_test.sv =====
// Testbench top for utf8_script_normalizer_top: clock, reset, stimulus and verdict.
// Drives directed and random UTF-8 text under each script mode; usn_stream_checker
// (and usn_pkg) does the prediction and comparison.
module utf8_script_normalizer_top_test;
    import usn_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 34;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;   // script_mode
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;       // [7:0] in_byte
    logic       s_tlast;       // end_of_text
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;       // [7:0] out_byte
    logic       m_tlast;       // run_last

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int items_sent;
    bit quiet;
    bit hold_req;

    utf8_script_normalizer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    usn_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // UTF-8 bytes of a code point, first byte in the low bits
    function automatic logic [31:0] utf8_pack(input logic [20:0] cp, output int len);
        if (cp < 21'h80) begin
            len = 1;
            utf8_pack = {24'd0, cp[7:0]};
        end else if (cp < 21'h800) begin
            len = 2;
            utf8_pack = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp < 21'h10000) begin
            len = 3;
            utf8_pack = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            len = 4;
            utf8_pack = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                         5'b11110, cp[20:18]};
        end
    endfunction

    function automatic logic [20:0] pick_codepoint();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:    pick_codepoint = 21'($urandom_range(0, 127));
            2:       pick_codepoint = 21'($urandom_range(21'h80, 21'h7FF));
            3, 4, 5: pick_codepoint = 21'($urandom_range(HANGUL_FIRST - 1, HANGUL_LAST + 1));
            6, 7:    pick_codepoint = 21'($urandom_range(KATA_FIRST - 1, KATA_LAST + 1));
            8:       pick_codepoint = 21'($urandom_range(21'h800, 21'hFFFF));
            default: pick_codepoint = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input logic [20:0] cp, input logic eot);
        logic [31:0] seq;
        int          len;
        seq = utf8_pack(cp, len);
        for (int i = 0; i < len; i++)
            send_byte(seq[8*i +: 8], eot && (i == len - 1));
    endtask

    // mostly well-formed characters, some noise and truncated sequences
    task automatic send_random_unit();
        logic [31:0] seq;
        int          len;
        int          cut;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            seq = utf8_pack(pick_codepoint(), len);
            cut = len;
            if (len > 1 && sel < 5)
                cut = $urandom_range(1, len - 1);
            for (int i = 0; i < cut; i++)
                send_byte(seq[8*i +: 8], (i == cut - 1) &&
                          ((cut < len && sel < 4) || $urandom_range(0, 5) == 0));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_count == 0);
    endtask

    // write only while idle; allow a lead byte still in flight to settle
    task automatic set_mode(input logic [1:0] mode);
        drain_results();
        repeat (12) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls, one long hold on request
    initial begin : sink
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [1:0] plan [$];
        int         phase_start;
        bit         paused;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = MODE_PASS;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        items_sent = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pass through copies any byte
        set_mode(MODE_PASS);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_mode(MODE_UNUSED);
        send_byte(8'hE3, 1'b0);
        send_byte(8'h80, 1'b1);

        set_mode(MODE_HANGUL);
        send_byte(8'h41, 1'b0);
        send_text(HANGUL_FIRST, 1'b0);
        send_text(HANGUL_LAST, 1'b0);
        // invalid leads are dropped
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b1);
        send_text(21'h1F600, 1'b0);
        // end of text on a lead, then inside a sequence
        send_byte(8'hE3, 1'b1);
        send_byte(8'hE3, 1'b0);
        send_byte(8'h81, 1'b1);
        // open a Katakana sequence, finish it under Kana mode
        send_byte(8'hE3, 1'b0);
        send_byte(8'h82, 1'b0);
        set_mode(MODE_KANA);
        send_byte(8'hA1, 1'b0);
        send_text(KATA_LAST, 1'b1);

        plan = '{MODE_HANGUL, MODE_KANA, MODE_PASS, MODE_HANGUL,
                 MODE_UNUSED, MODE_KANA, MODE_HANGUL};
        for (int p = 0; p < plan.size(); p++) begin
            if (p == plan.size() - 1)
                quiet = 1'b1;
            set_mode(plan[p]);
            if (p == 1)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (p == 3 && !paused && items_sent - phase_start >= 20) begin
                    drain_results();
                    paused = 1'b1;
                end
                send_random_unit();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
